@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/pimp_pkg.sv @@
// Shared types and constants of the peer identify message parser.
`default_nettype none

package pimp_pkg;

    // Record kinds carried on the result side.
    typedef enum logic [1:0] {
        KIND_ENTRY    = 2'd0,
        KIND_OBSERVED = 2'd1,
        KIND_ACCEPT   = 2'd2,
        KIND_REJECT   = 2'd3
    } kind_t;

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ADDRESSES    = 2'd1;

    // Register reset values.
    localparam logic [7:0] VERSION_RESET   = 8'd1;
    localparam logic [7:0] MAX_ADDR_RESET  = 8'd16;

    // Address length codes and their byte counts.
    localparam logic [7:0] LEN_NONE = 8'd0;
    localparam logic [7:0] LEN_V4   = 8'd4;
    localparam logic [7:0] LEN_V6   = 8'd16;
    localparam logic [4:0] V4_BYTES = 5'd4;
    localparam logic [4:0] V6_BYTES = 5'd16;

    // Default depth of the record queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One result record.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] hdr_port;
        logic [7:0]  entry_index;
        logic        ip_is_v6;
        logic [63:0] ip_upper;
        logic [63:0] ip_lower;
        logic [15:0] addr_port;
        logic        last_result;
    } rec_t;

    // Records produced by one byte: an address record, then a verdict.
    typedef struct packed {
        logic addr_valid;
        logic verdict_valid;
        rec_t addr_rec;
        rec_t verdict_rec;
    } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/pimp_front.sv @@
// Byte-level message parser: tracks the message layout and produces records.
`default_nettype none

`include "assert_macros.svh"

module pimp_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [7:0]                      byte_value,
    input  wire logic                            last_byte,
    input  wire logic                            cfg_write_en,
    input  wire logic [pimp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data,
    output pimp_pkg::push_t                      push_rec
);

    typedef enum logic [3:0] {
        PH_VERSION,
        PH_PORT_HI,
        PH_PORT_LO,
        PH_COUNT,
        PH_ALEN,
        PH_IP,
        PH_APORT_HI,
        PH_APORT_LO,
        PH_DONE,
        PH_FAILED
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [4:0]  bcnt_reg,     bcnt_next;
    logic [7:0]  expect_reg,   expect_next;
    logic [7:0]  seen_reg,     seen_next;
    logic [63:0] ip_hi_reg,    ip_hi_next;
    logic [63:0] ip_lo_reg,    ip_lo_next;
    logic        wide_reg,     wide_next;
    logic [7:0]  port_hi_reg,  port_hi_next;
    logic [15:0] listen_reg,   listen_next;
    logic        observed_reg, observed_next;
    logic [7:0]  version_reg,  version_next;
    logic [7:0]  max_addr_reg, max_addr_next;
    logic [4:0]  bcnt_inc;
    logic [4:0]  bcnt_limit;

    // Configuration writes; other indexes are ignored.
    always_comb
    begin
        version_next  = version_reg;
        max_addr_next = max_addr_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                pimp_pkg::REG_EXPECTED_VERSION: version_next  = cfg_data;
                pimp_pkg::REG_MAX_ADDRESSES:    max_addr_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign bcnt_inc   = bcnt_reg + 5'd1;
    assign bcnt_limit = wide_reg ? pimp_pkg::V6_BYTES : pimp_pkg::V4_BYTES;

    // Parse step for an accepted byte, with the verdict on the last byte.
    always_comb
    begin
        phase_next    = phase_reg;
        bcnt_next     = bcnt_reg;
        expect_next   = expect_reg;
        seen_next     = seen_reg;
        ip_hi_next    = ip_hi_reg;
        ip_lo_next    = ip_lo_reg;
        wide_next     = wide_reg;
        port_hi_next  = port_hi_reg;
        listen_next   = listen_reg;
        observed_next = observed_reg;
        push_rec      = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_VERSION:
                begin
                    phase_next = (byte_value == version_reg) ? PH_PORT_HI : PH_FAILED;
                end
                PH_PORT_HI:
                begin
                    port_hi_next = byte_value;
                    phase_next   = PH_PORT_LO;
                end
                PH_PORT_LO:
                begin
                    listen_next = {port_hi_reg, byte_value};
                    phase_next  = PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (byte_value > max_addr_reg)
                    begin
                        phase_next = PH_FAILED;
                    end
                    else
                    begin
                        expect_next   = byte_value;
                        seen_next     = 8'd0;
                        observed_next = (byte_value == 8'd0);
                        phase_next    = PH_ALEN;
                    end
                end
                PH_ALEN:
                begin
                    ip_hi_next = 64'd0;
                    ip_lo_next = 64'd0;
                    bcnt_next  = 5'd0;
                    if (observed_reg && (byte_value == pimp_pkg::LEN_NONE))
                    begin
                        phase_next = PH_DONE;
                    end
                    else if ((byte_value == pimp_pkg::LEN_V4) ||
                             (byte_value == pimp_pkg::LEN_V6))
                    begin
                        wide_next  = (byte_value == pimp_pkg::LEN_V6);
                        phase_next = PH_IP;
                    end
                    else
                    begin
                        phase_next = PH_FAILED;
                    end
                end
                PH_IP:
                begin
                    // The 128-bit address shifts in one byte at a time.
                    ip_hi_next = {ip_hi_reg[55:0], ip_lo_reg[63:56]};
                    ip_lo_next = {ip_lo_reg[55:0], byte_value};
                    bcnt_next  = bcnt_inc;
                    if (bcnt_inc >= bcnt_limit)
                    begin
                        phase_next = PH_APORT_HI;
                    end
                end
                PH_APORT_HI:
                begin
                    port_hi_next = byte_value;
                    phase_next   = PH_APORT_LO;
                end
                PH_APORT_LO:
                begin
                    push_rec.addr_valid           = 1'b1;
                    push_rec.addr_rec.hdr_port    = listen_reg;
                    push_rec.addr_rec.ip_is_v6    = wide_reg;
                    push_rec.addr_rec.ip_upper    = ip_hi_reg;
                    push_rec.addr_rec.ip_lower    = ip_lo_reg;
                    push_rec.addr_rec.addr_port   = {port_hi_reg, byte_value};
                    push_rec.addr_rec.last_result = 1'b0;
                    if (observed_reg)
                    begin
                        push_rec.addr_rec.kind        = pimp_pkg::KIND_OBSERVED;
                        push_rec.addr_rec.entry_index = 8'd0;
                        phase_next                    = PH_DONE;
                    end
                    else
                    begin
                        push_rec.addr_rec.kind        = pimp_pkg::KIND_ENTRY;
                        push_rec.addr_rec.entry_index = seen_reg;
                        seen_next                     = seen_reg + 8'd1;
                        if ((seen_reg + 8'd1) >= expect_reg)
                        begin
                            observed_next = 1'b1;
                        end
                        phase_next = PH_ALEN;
                    end
                end
                default: ;
            endcase

            // The last byte closes the message with a verdict and restarts parsing.
            if (last_byte)
            begin
                push_rec.verdict_valid           = 1'b1;
                push_rec.verdict_rec.kind        = (phase_next == PH_DONE) ?
                                                   pimp_pkg::KIND_ACCEPT :
                                                   pimp_pkg::KIND_REJECT;
                push_rec.verdict_rec.hdr_port    = listen_next;
                push_rec.verdict_rec.last_result = 1'b1;
                phase_next    = PH_VERSION;
                bcnt_next     = 5'd0;
                expect_next   = 8'd0;
                seen_next     = 8'd0;
                ip_hi_next    = 64'd0;
                ip_lo_next    = 64'd0;
                wide_next     = 1'b0;
                port_hi_next  = 8'd0;
                listen_next   = 16'd0;
                observed_next = 1'b0;
            end
        end
    end

    // Parser state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_VERSION;
            bcnt_reg     <= 5'd0;
            expect_reg   <= 8'd0;
            seen_reg     <= 8'd0;
            ip_hi_reg    <= 64'd0;
            ip_lo_reg    <= 64'd0;
            wide_reg     <= 1'b0;
            port_hi_reg  <= 8'd0;
            listen_reg   <= 16'd0;
            observed_reg <= 1'b0;
            version_reg  <= pimp_pkg::VERSION_RESET;
            max_addr_reg <= pimp_pkg::MAX_ADDR_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            bcnt_reg     <= bcnt_next;
            expect_reg   <= expect_next;
            seen_reg     <= seen_next;
            ip_hi_reg    <= ip_hi_next;
            ip_lo_reg    <= ip_lo_next;
            wide_reg     <= wide_next;
            port_hi_reg  <= port_hi_next;
            listen_reg   <= listen_next;
            observed_reg <= observed_next;
            version_reg  <= version_next;
            max_addr_reg <= max_addr_next;
        end
    end

    // A verdict always leaves the parser waiting for the next version byte.
    `ASSERT_NEXT(a_verdict_restart, clk, rst_n, push_rec.verdict_valid, phase_reg == PH_VERSION)

    // An address record is only produced while an address port is being completed.
    `ASSERT_NEXT(a_addr_after_port, clk, rst_n, push_rec.addr_valid && !last_byte,
                 phase_reg == PH_ALEN || phase_reg == PH_DONE)

endmodule

`default_nettype wire

@@ hw/rtl/pimp_queue.sv @@
// Record queue between the parser and the result side, taking up to two records a cycle.
`default_nettype none

`include "assert_macros.svh"

module pimp_queue #(
    parameter int Depth = pimp_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pimp_pkg::push_t push_rec,
    input  wire logic            pop,
    output logic                 full,
    output logic                 empty,
    output pimp_pkg::rec_t       head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    pimp_pkg::rec_t mem [Depth];

    logic [PtrW-1:0] head_reg, head_next;
    logic [PtrW-1:0] tail_reg, tail_next;
    logic [CntW-1:0] cnt_reg,  cnt_next;
    logic [PtrW-1:0] tail_inc;
    logic [PtrW-1:0] tail_inc2;
    logic [PtrW-1:0] head_inc;
    logic            first_we;
    logic            second_we;
    pimp_pkg::rec_t  first_rec;
    logic [CntW-1:0] n_push;
    logic            pop_ok;

    function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
        wrap_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign tail_inc  = wrap_inc(tail_reg);
    assign tail_inc2 = wrap_inc(tail_inc);
    assign head_inc  = wrap_inc(head_reg);

    // Room is always kept for the two records one byte can produce.
    assign full  = (cnt_reg >= CntW'(Depth - 1));
    assign empty = (cnt_reg == '0);
    assign pop_ok = pop && !empty;
    assign head  = mem[head_reg];

    // The address record goes first; a verdict alone takes the tail slot.
    assign first_we  = push_rec.addr_valid || push_rec.verdict_valid;
    assign second_we = push_rec.addr_valid && push_rec.verdict_valid;
    assign first_rec = push_rec.addr_valid ? push_rec.addr_rec : push_rec.verdict_rec;
    assign n_push    = CntW'(push_rec.addr_valid) + CntW'(push_rec.verdict_valid);

    // Pointer and occupancy update.
    always_comb
    begin
        head_next = pop_ok ? head_inc : head_reg;
        tail_next = second_we ? tail_inc2 : (first_we ? tail_inc : tail_reg);
        cnt_next  = cnt_reg + n_push - CntW'(pop_ok);
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            mem[tail_reg] <= first_rec;
        end
        if (second_we)
        begin
            mem[tail_inc] <= push_rec.verdict_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Records only arrive while the queue still has room for both of them.
    `ASSERT_SAME(a_no_overflow, clk, rst_n, first_we, cnt_reg <= CntW'(Depth - 2))

    // A transfer out with nothing arriving shrinks the queue by exactly one.
    `ASSERT_NEXT(a_pop_count, clk, rst_n, pop_ok && !first_we,
                 cnt_reg == $past(cnt_reg) - CntW'(1))

endmodule

`default_nettype wire

@@ hw/rtl/peer_identify_message_parser.sv @@
// Top level of the peer identify message parser: byte input, record queue output.
// A record is written into the queue at the clock edge that accepts the byte completing it.
// Throughput: one byte per cycle unless full; a byte may give two records (address, verdict).
// full rises while the record queue has fewer than two free slots; Depth sets that slack.
// Reset (rst_n low, asynchronous) empties the queue and restarts parsing at the version byte;
// the registers return to expected_version 1 and max_addresses 16.
`default_nettype none

module peer_identify_message_parser #(
    parameter int Depth = pimp_pkg::QUEUE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [7:0]                       byte_value,
    input  wire logic                             last_byte,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [1:0]                            record_kind,
    output logic [15:0]                           hdr_port,
    output logic [7:0]                            entry_index,
    output logic                                  ip_is_v6,
    output logic [63:0]                           ip_upper,
    output logic [63:0]                           ip_lower,
    output logic [15:0]                           addr_port,
    output logic                                  last_result,
    input  wire logic                             cfg_write_en,
    input  wire logic [pimp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    logic            accept;
    pimp_pkg::push_t push_rec;
    pimp_pkg::rec_t  head;

    // A byte transfer happens whenever push is high and the queue has room for two records.
    assign accept = push && !full;

    pimp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push_rec     (push_rec)
    );

    pimp_queue #(
        .Depth (Depth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    // Oldest waiting record onto the result ports.
    assign record_kind = head.kind;
    assign hdr_port    = head.hdr_port;
    assign entry_index = head.entry_index;
    assign ip_is_v6    = head.ip_is_v6;
    assign ip_upper    = head.ip_upper;
    assign ip_lower    = head.ip_lower;
    assign addr_port   = head.addr_port;
    assign last_result = head.last_result;

endmodule

`default_nettype wire

@@ tb/tb_peer_identify_message_parser.sv @@
// Self-checking testbench for the peer identify message parser: byte stream in, records out.
module tb_peer_identify_message_parser;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that the block decodes to nothing.
    localparam logic [pimp_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [pimp_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    // Parser stages of the prediction.
    typedef enum logic [3:0] {
        ST_VERSION,
        ST_PORT_HI,
        ST_PORT_LO,
        ST_COUNT,
        ST_LENGTH,
        ST_IP,
        ST_APORT_HI,
        ST_APORT_LO,
        ST_DONE,
        ST_FAILED
    } stage_t;

    // One byte waiting to be offered to the block.
    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } byte_item_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             push = 1'b0;
    logic                             full;
    logic [7:0]                       byte_value = 8'h00;
    logic                             last_byte = 1'b0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic [1:0]                       record_kind;
    logic [15:0]                      hdr_port;
    logic [7:0]                       entry_index;
    logic                             ip_is_v6;
    logic [63:0]                      ip_upper;
    logic [63:0]                      ip_lower;
    logic [15:0]                      addr_port;
    logic                             last_result;
    logic                             cfg_write_en = 1'b0;
    logic [pimp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]                       cfg_data = 8'h00;

    // Register copies held by the prediction.
    logic [7:0]  want_version = pimp_pkg::VERSION_RESET;
    logic [7:0]  addr_limit = pimp_pkg::MAX_ADDR_RESET;

    // Parse state of the prediction.
    stage_t      stage;
    logic [4:0]  ip_count;
    logic [7:0]  count_wanted;
    logic [7:0]  count_done;
    logic [63:0] ip_hi;
    logic [63:0] ip_lo;
    logic        wide;
    logic [7:0]  port_msb;
    logic [15:0] listen_held;
    logic        in_observed;

    byte_item_t      pending_bytes[$];
    pimp_pkg::rec_t  expected_records[$];
    logic [7:0]      msg[$];
    int              len_slots[$];
    int              bytes_queued = 0;
    int              bytes_taken = 0;
    int              mismatches = 0;

    int          send_wait = 0;
    bit          send_calm = 1'b0;
    int          recv_wait = 0;
    bit          recv_calm = 1'b0;
    byte_item_t  next_item;

    peer_identify_message_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .empty        (empty),
        .pop          (pop),
        .record_kind  (record_kind),
        .hdr_port     (hdr_port),
        .entry_index  (entry_index),
        .ip_is_v6     (ip_is_v6),
        .ip_upper     (ip_upper),
        .ip_lower     (ip_lower),
        .addr_port    (addr_port),
        .last_result  (last_result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock and the single reset pulse.
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Return the parse state to the start of a message.
    task automatic restart_parse();
        stage = ST_VERSION;
        ip_count = '0;
        count_wanted = '0;
        count_done = '0;
        ip_hi = '0;
        ip_lo = '0;
        wide = 1'b0;
        port_msb = '0;
        listen_held = '0;
        in_observed = 1'b0;
    endtask

    function automatic pimp_pkg::rec_t make_record(pimp_pkg::kind_t kind, logic [7:0] idx,
                                                   logic v6, logic [63:0] up,
                                                   logic [63:0] lo, logic [15:0] port,
                                                   logic fin);
        pimp_pkg::rec_t r;
        r.kind = kind;
        r.hdr_port = listen_held;
        r.entry_index = idx;
        r.ip_is_v6 = v6;
        r.ip_upper = up;
        r.ip_lower = lo;
        r.addr_port = port;
        r.last_result = fin;
        return r;
    endfunction

    // Append one record to the tail of the expected list.
    task automatic expect_rec(input pimp_pkg::rec_t r);
        expected_records.insert(expected_records.size(), r);
    endtask

    // Append one byte to the message being built.
    task automatic msg_add(input logic [7:0] v);
        msg.insert(msg.size(), v);
    endtask

    // Advance the parse by one accepted byte and queue the records it yields.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        case (stage)
            ST_VERSION:
                stage = (b == want_version) ? ST_PORT_HI : ST_FAILED;
            ST_PORT_HI:
            begin
                port_msb = b;
                stage = ST_PORT_LO;
            end
            ST_PORT_LO:
            begin
                listen_held = {port_msb, b};
                stage = ST_COUNT;
            end
            ST_COUNT:
            begin
                if (b > addr_limit)
                begin
                    stage = ST_FAILED;
                end
                else
                begin
                    count_wanted = b;
                    count_done = '0;
                    in_observed = (b == 8'd0);
                    stage = ST_LENGTH;
                end
            end
            ST_LENGTH:
            begin
                ip_hi = '0;
                ip_lo = '0;
                ip_count = '0;
                if (in_observed && b == pimp_pkg::LEN_NONE)
                begin
                    stage = ST_DONE;
                end
                else if (b == pimp_pkg::LEN_V4 || b == pimp_pkg::LEN_V6)
                begin
                    wide = (b == pimp_pkg::LEN_V6);
                    stage = ST_IP;
                end
                else
                begin
                    stage = ST_FAILED;
                end
            end
            ST_IP:
            begin
                {ip_hi, ip_lo} = {ip_hi[55:0], ip_lo, b};
                ip_count = ip_count + 5'd1;
                if (ip_count >= (wide ? pimp_pkg::V6_BYTES : pimp_pkg::V4_BYTES))
                    stage = ST_APORT_HI;
            end
            ST_APORT_HI:
            begin
                port_msb = b;
                stage = ST_APORT_LO;
            end
            ST_APORT_LO:
            begin
                if (in_observed)
                begin
                    expect_rec(make_record(pimp_pkg::KIND_OBSERVED, 8'd0, wide,
                                           ip_hi, ip_lo, {port_msb, b}, 1'b0));
                    stage = ST_DONE;
                end
                else
                begin
                    expect_rec(make_record(pimp_pkg::KIND_ENTRY, count_done, wide,
                                           ip_hi, ip_lo, {port_msb, b}, 1'b0));
                    count_done = count_done + 8'd1;
                    if (count_done >= count_wanted)
                        in_observed = 1'b1;
                    stage = ST_LENGTH;
                end
            end
            default:
            begin
            end
        endcase

        // The flagged byte closes the message with its verdict.
        if (fin)
        begin
            if (stage == ST_DONE)
                expect_rec(make_record(pimp_pkg::KIND_ACCEPT, 8'd0, 1'b0, '0, '0,
                                       16'd0, 1'b1));
            else
                expect_rec(make_record(pimp_pkg::KIND_REJECT, 8'd0, 1'b0, '0, '0,
                                       16'd0, 1'b1));
            restart_parse();
        end
    endtask

    initial
    begin
        restart_parse();
    end

    // Byte driver: offers queued bytes, holding each until its transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                parse_byte(byte_value, last_byte);
                bytes_taken++;
            end
            if (!(push && full))
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    push <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_item = pending_bytes.pop_front();
                    byte_value <= next_item.value;
                    last_byte <= next_item.fin;
                    push <= 1'b1;
                    if ($urandom_range(0, 40) == 0)
                        send_calm = !send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, 14);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Record monitor: compares each transfer with the oldest expected record.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("record_kind: expected nothing, got %0h", record_kind);
                    mismatches++;
                end
                else
                begin
                    check_field("record_kind", expected_records[0].kind, record_kind);
                    check_field("hdr_port", expected_records[0].hdr_port, hdr_port);
                    check_field("entry_index", expected_records[0].entry_index, entry_index);
                    check_field("ip_is_v6", expected_records[0].ip_is_v6, ip_is_v6);
                    check_field("ip_upper", expected_records[0].ip_upper, ip_upper);
                    check_field("ip_lower", expected_records[0].ip_lower, ip_lower);
                    check_field("addr_port", expected_records[0].addr_port, addr_port);
                    check_field("last_result", expected_records[0].last_result, last_result);
                    void'(expected_records.pop_front());
                end
                if ($urandom_range(0, 40) == 0)
                    recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
            end
            if (recv_wait != 0)
            begin
                recv_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic add_item(input logic [7:0] value, input logic fin);
        byte_item_t item;
        item.value = value;
        item.fin = fin;
        pending_bytes.insert(pending_bytes.size(), item);
        bytes_queued++;
    endtask

    // Mostly random bytes, with the all-zero and all-one values now and then.
    function automatic logic [7:0] fill_byte();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic build_header(input logic [7:0] version, input logic [7:0] count);
        msg.delete();
        len_slots.delete();
        msg_add(version);
        msg_add(fill_byte());
        msg_add(fill_byte());
        msg_add(count);
    endtask

    task automatic put_address(input logic [7:0] len);
        len_slots.insert(len_slots.size(), msg.size());
        msg_add(len);
        if (len != pimp_pkg::LEN_NONE)
        begin
            repeat ((len == pimp_pkg::LEN_V6) ? pimp_pkg::V6_BYTES : pimp_pkg::V4_BYTES)
                msg_add(fill_byte());
            msg_add(fill_byte());
            msg_add(fill_byte());
        end
    endtask

    task automatic build_message(input logic [7:0] version, input logic [7:0] count,
                                 input bit observed);
        build_header(version, count);
        for (int i = 0; i < count; i++)
            put_address(($urandom_range(0, 3) == 0) ? pimp_pkg::LEN_V6 : pimp_pkg::LEN_V4);
        if (observed)
            put_address(($urandom_range(0, 3) == 0) ? pimp_pkg::LEN_V6 : pimp_pkg::LEN_V4);
        else
            put_address(pimp_pkg::LEN_NONE);
    endtask

    // Queue msg[first .. stop-1], flagging the final byte when the message ends there.
    task automatic queue_span(input int first, input int stop, input bit close);
        for (int i = first; i < stop; i++)
            add_item(msg[i], close && (i == stop - 1));
    endtask

    function automatic logic [7:0] pick_count();
        if (addr_limit <= 8'd12 && $urandom_range(0, 7) == 0)
            return addr_limit;
        return 8'($urandom_range(0, (addr_limit < 8'd5) ? addr_limit : 5));
    endfunction

    // One message: mostly well formed, the rest broken in one of several ways.
    task automatic one_message();
        int   pick;
        int   slot;
        int   n;
        bit   obs;
        logic [7:0] bad;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            build_message(want_version, pick_count(), 1'($urandom_range(0, 1)));
            // Trailing bytes after a complete message are ignored.
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) msg_add(fill_byte());
            queue_span(0, msg.size(), 1'b1);
        end
        else if (pick < 68 || (pick < 76 && addr_limit == 8'hFF))
        begin
            build_header(want_version ^ 8'($urandom_range(1, 255)), fill_byte());
            repeat ($urandom_range(0, 3)) msg_add(fill_byte());
            queue_span(0, msg.size(), 1'b1);
        end
        else if (pick < 76)
        begin
            build_header(want_version, 8'($urandom_range(addr_limit + 1, 255)));
            repeat ($urandom_range(0, 3)) msg_add(fill_byte());
            queue_span(0, msg.size(), 1'b1);
        end
        else if (pick < 84)
        begin
            // Corrupt one length byte; the observed slot is always the last one.
            build_message(want_version, pick_count(), 1'($urandom_range(0, 1)));
            slot = $urandom_range(0, len_slots.size() - 1);
            obs = (slot == len_slots.size() - 1);
            do
                bad = 8'($urandom_range(0, 255));
            while (bad == pimp_pkg::LEN_V4 || bad == pimp_pkg::LEN_V6 ||
                   (obs && bad == pimp_pkg::LEN_NONE));
            msg[len_slots[slot]] = bad;
            queue_span(0, msg.size(), 1'b1);
        end
        else if (pick < 94)
        begin
            build_message(want_version, pick_count(), 1'($urandom_range(0, 1)));
            queue_span(0, $urandom_range(1, msg.size() - 1), 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_item(fill_byte(), (i == n - 1) || ($urandom_range(0, 3) == 0));
        end
    endtask

    task automatic write_reg(input logic [pimp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == pimp_pkg::REG_EXPECTED_VERSION)
            want_version = val;
        else if (idx == pimp_pkg::REG_MAX_ADDRESSES)
            addr_limit = val;
    endtask

    // Wait until every byte has been taken and every record has arrived.
    task automatic settle();
        while (bytes_taken != bytes_queued || expected_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Stimulus: directed messages, then random traffic under several settings.
    initial
    begin : stimulus
        logic [7:0] next_version;
        logic [7:0] next_limit;
        repeat (12) @(posedge clk);

        // Shortest accepted message, listen port at its maximum.
        add_item(pimp_pkg::VERSION_RESET, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'd0, 1'b0);
        add_item(pimp_pkg::LEN_NONE, 1'b1);
        // Wrong version on a lone last byte.
        add_item(8'h00, 1'b1);
        // Address count one above the limit.
        add_item(pimp_pkg::VERSION_RESET, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(pimp_pkg::MAX_ADDR_RESET + 8'd1, 1'b1);
        // Entry length that is neither four nor sixteen.
        add_item(pimp_pkg::VERSION_RESET, 1'b0);
        add_item(8'h12, 1'b0);
        add_item(8'h34, 1'b0);
        add_item(8'd1, 1'b0);
        add_item(pimp_pkg::LEN_V4 + 8'd1, 1'b1);
        // Entry completed on the last byte: emitted, then the message is rejected.
        add_item(pimp_pkg::VERSION_RESET, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'd1, 1'b0);
        add_item(pimp_pkg::LEN_V4, 1'b0);
        repeat (5) add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b1);
        settle();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    next_version = pimp_pkg::VERSION_RESET;
                    next_limit = pimp_pkg::MAX_ADDR_RESET;
                end
                1:
                begin
                    next_version = 8'h00;
                    next_limit = 8'h00;
                end
                2:
                begin
                    next_version = 8'hFF;
                    next_limit = 8'hFF;
                end
                3:
                begin
                    next_version = 8'($urandom_range(0, 255));
                    next_limit = 8'($urandom_range(1, 4));
                end
                4:
                begin
                    next_version = 8'($urandom_range(0, 255));
                    next_limit = 8'($urandom_range(5, 12));
                end
                5:
                begin
                    next_version = 8'($urandom_range(0, 255));
                    next_limit = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    next_version = pimp_pkg::VERSION_RESET;
                    next_limit = 8'($urandom_range(0, 16));
                end
            endcase

            if (ph == 4)
            begin
                // A message straddles the change: its count only passes the new limit.
                build_message(want_version, next_limit, 1'($urandom_range(0, 1)));
                queue_span(0, 3, 1'b0);
                settle();
                write_reg(pimp_pkg::REG_EXPECTED_VERSION, next_version);
                write_reg(pimp_pkg::REG_MAX_ADDRESSES, next_limit);
                queue_span(3, msg.size(), 1'b1);
            end
            else
            begin
                if (ph == 3)
                begin
                    write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
                    write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
                end
                write_reg(pimp_pkg::REG_EXPECTED_VERSION, next_version);
                write_reg(pimp_pkg::REG_MAX_ADDRESSES, next_limit);
            end

            begin : traffic
                int target;
                target = bytes_queued + 220;
                while (bytes_queued < target)
                    one_message();
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a run that never drains.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pimp_pkg.sv
hw/rtl/pimp_front.sv
hw/rtl/pimp_queue.sv
hw/rtl/peer_identify_message_parser.sv
tb/tb_peer_identify_message_parser.sv
